[rtl/fexp_pkg.sv]
`default_nettype none
package fexp_pkg;

  typedef struct packed {
    logic [31:0] x_bits;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [31:0] y_bits;
    logic        last_out;
  } out_t;

  // one pipeline slot: valid, side band, override result, working registers
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        ovr;
    logic [31:0] ovr_bits;
    logic [31:0] acc;
    logic [31:0] t;
    logic [31:0] pow2;
  } pipe_t;

  typedef enum logic {OP_MUL, OP_ADD} fop_t;
  typedef enum logic [1:0] {SRC_CONST, SRC_T, SRC_ACC, SRC_POW2} src_t;

  localparam logic [31:0] F_Q       = 32'h3EB8AA3B; // log2(e) * 0.25
  localparam logic [31:0] F_LN2     = 32'h3F317218;
  localparam logic [31:0] F_HALF    = 32'h3F000000;
  localparam logic [31:0] F_FIFTH   = 32'h3E4CCCCD;
  localparam logic [31:0] F_QUARTER = 32'h3E800000;
  localparam logic [31:0] F_THIRD   = 32'h3EAAAAAB;
  localparam logic [31:0] F_ONE     = 32'h3F800000;
  localparam logic [31:0] F_PINF    = 32'h7F800000;
  localparam logic [31:0] F_QNAN    = 32'h00400000;
  localparam logic [31:0] F_ZLIM    = 32'h42800000; // 64.0

  localparam int NOPS = 21;
  localparam int LAT  = NOPS + 1;

  // operation table; the floor stage sits between entry 0 and entry 1
  localparam fop_t OP_TAB [NOPS] = '{
    OP_MUL, OP_ADD, OP_MUL, OP_MUL, OP_MUL, OP_ADD, OP_MUL, OP_MUL, OP_ADD, OP_MUL,
    OP_MUL, OP_ADD, OP_MUL, OP_MUL, OP_ADD, OP_MUL, OP_ADD, OP_MUL, OP_MUL, OP_MUL,
    OP_MUL};
  localparam src_t SRC_TAB [NOPS] = '{
    SRC_CONST, SRC_T, SRC_CONST, SRC_CONST, SRC_CONST, SRC_CONST, SRC_T, SRC_CONST,
    SRC_CONST, SRC_T, SRC_CONST, SRC_CONST, SRC_T, SRC_CONST, SRC_CONST, SRC_T,
    SRC_CONST, SRC_ACC, SRC_POW2, SRC_ACC, SRC_ACC};
  localparam logic [31:0] CONST_TAB [NOPS] = '{
    F_Q, F_ONE, F_HALF, F_LN2, F_FIFTH, F_ONE, F_ONE, F_QUARTER, F_ONE, F_ONE,
    F_THIRD, F_ONE, F_ONE, F_HALF, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, F_ONE};
  localparam logic WRT_TAB [NOPS] = '{
    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  function automatic logic [5:0] lzc50(input logic [49:0] v);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  // round to nearest even and pack; sig has its leading one at bit 47
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] e,
                                             input logic [47:0] sig);
    logic signed [11:0] tmp;
    logic [5:0]  sh;
    logic [7:0]  ef;
    logic [47:0] m;
    logic        stk;
    logic        inc;
    logic [30:0] mag;
    tmp = 12'sd1 - e;
    if (e >= 12'sd1) begin
      sh = 6'd0;
      ef = e[7:0];
    end else begin
      sh = (tmp > 12'sd48) ? 6'd48 : tmp[5:0];
      ef = 8'd0;
    end
    m   = sig >> sh;
    stk = (|(sig & ((48'd1 << sh) - 48'd1))) | (|m[22:0]);
    inc = m[23] & (stk | m[24]);
    mag = {ef, m[46:24]} + {30'd0, inc};
    if (e >= 12'sd255) return {sgn, 8'hFF, 23'd0};
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic        s;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic [47:0] p;
    logic [5:0]  lz;
    logic signed [11:0] e;
    s  = a[31] ^ b[31];
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    lz = lzc50({p, 2'b00});
    e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {s, 8'hFF, 23'd0};
    if (p == 48'd0) return {s, 31'd0};
    return round_pack(s, e, p << lz);
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big, sml;
    logic [7:0]  ea, eb, d;
    logic [23:0] ma, mb;
    logic [47:0] b0, bs;
    logic        stk;
    logic [49:0] av, bv, sv, sn;
    logic [5:0]  lz;
    logic signed [11:0] e;
    if (b[30:0] > a[30:0]) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    ea = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    eb = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    ma = {big[30:23] != 8'd0, big[22:0]};
    mb = {sml[30:23] != 8'd0, sml[22:0]};
    d  = ea - eb;
    b0 = {mb, 24'd0};
    if (d >= 8'd48) begin
      bs  = 48'd0;
      stk = |b0;
    end else begin
      bs  = b0 >> d;
      stk = |(b0 & ((48'd1 << d) - 48'd1));
    end
    av = {1'b0, ma, 25'd0};
    bv = {1'b0, bs, stk};
    sv = (big[31] ^ sml[31]) ? (av - bv) : (av + bv);
    lz = lzc50(sv);
    sn = sv << lz;
    e  = $signed({4'd0, ea}) + 12'sd1 - $signed({6'd0, lz});
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (sv == 50'd0) return 32'd0;
    return round_pack(big[31], e, {sn[49:3], |sn[2:0]});
  endfunction

endpackage
`default_nettype wire

[rtl/fexp_fop.sv]
`default_nettype none
module fexp_fop #(
  parameter fexp_pkg::fop_t    OP   = fexp_pkg::OP_MUL,
  parameter fexp_pkg::src_t    SRC  = fexp_pkg::SRC_CONST,
  parameter logic [31:0]       KVAL = fexp_pkg::F_ONE,
  parameter logic              WRT  = 1'b0
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fexp_pkg::pipe_t i_pipe,
  output fexp_pkg::pipe_t      o_pipe
);

  fexp_pkg::pipe_t pipe_r, pipe_nxt;
  logic [31:0]     opb;
  logic [31:0]     res;

  always_comb begin
    case (SRC)
      fexp_pkg::SRC_T:    opb = i_pipe.t;
      fexp_pkg::SRC_ACC:  opb = i_pipe.acc;
      fexp_pkg::SRC_POW2: opb = i_pipe.pow2;
      default:            opb = KVAL;
    endcase
    if (OP == fexp_pkg::OP_MUL) res = fexp_pkg::fmul(i_pipe.acc, opb);
    else res = fexp_pkg::fadd(i_pipe.acc, opb);
    pipe_nxt       = i_pipe;
    // drop the slot while in reset
    pipe_nxt.valid = i_pipe.valid & rst_n;
    pipe_nxt.acc   = res;
    if (WRT) pipe_nxt.t = res;
  end

  always_ff @(posedge clk) begin
    pipe_r <= pipe_nxt;
  end

  assign o_pipe = pipe_r;

endmodule
`default_nettype wire

[rtl/fexp_floor.sv]
`default_nettype none
module fexp_floor (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire fexp_pkg::pipe_t i_pipe,
  output fexp_pkg::pipe_t      o_pipe
);

  fexp_pkg::pipe_t pipe_r, pipe_nxt;
  logic [31:0] z;
  logic [23:0] mant;
  logic [2:0]  k;
  logic [4:0]  rs;
  logic [6:0]  ip;
  logic        fr;
  logic [7:0]  n;
  logic [6:0]  mag;
  logic [2:0]  pos;
  logic [22:0] frac;

  always_comb begin
    z    = i_pipe.acc;
    mant = {1'b1, z[22:0]};
    k    = (z[30:23] > 8'd133) ? 3'd6 : 3'(z[30:23] - 8'd127);
    rs   = 5'd23 - {2'd0, k};
    if (z[30:23] < 8'd127) begin
      ip = 7'd0;
      fr = (z[30:0] != 31'd0);
    end else begin
      ip = 7'(mant >> rs);
      fr = |(mant & ((24'd1 << rs) - 24'd1));
    end
    // floor: round toward minus infinity for negative values
    n   = z[31] ? (8'd0 - {1'd0, ip} - {7'd0, fr}) : {1'd0, ip};
    mag = n[7] ? 7'(8'd0 - n) : n[6:0];
    pos = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (mag[i]) pos = 3'(i);
    end
    frac = 23'({16'd0, mag} << (5'd23 - {2'd0, pos}));

    pipe_nxt       = i_pipe;
    // drop the slot while in reset
    pipe_nxt.valid = i_pipe.valid & rst_n;
    pipe_nxt.pow2  = {1'b0, n + 8'd127, 23'd0};
    // negated float(n); a zero n gives -0 so that -0 - 0 stays -0
    if (mag == 7'd0) pipe_nxt.t = {1'b1, 31'd0};
    else pipe_nxt.t = {~n[7], 8'd127 + {5'd0, pos}, frac};
    if (!i_pipe.ovr) begin
      if (!z[31] && z[30:0] >= fexp_pkg::F_ZLIM[30:0]) begin
        pipe_nxt.ovr      = 1'b1;
        pipe_nxt.ovr_bits = fexp_pkg::F_PINF;
      end else if (z[31] && z[30:0] > fexp_pkg::F_ZLIM[30:0]) begin
        pipe_nxt.ovr      = 1'b1;
        pipe_nxt.ovr_bits = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pipe_r <= pipe_nxt;
  end

  assign o_pipe = pipe_r;

endmodule
`default_nettype wire

[rtl/float32_exp_approx.sv]
// Pipeline: 22 register stages from the input transfer to the result transfer.
// Throughput: one element per cycle; busy is always low, one float op per stage apart from the floor stage.
// Each stage holds one rounded binary32 multiply or add (24x24 multiplier or
// align/add/normalize); the floor stage builds floor(z), -n and 2^n.
// Reset (synchronous, rst_n low) clears the stage valid bits only.
// The receiver cannot stall: out_strobe marks each result for one cycle.
`default_nettype none
module float32_exp_approx (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire fexp_pkg::in_t in_data,
  output logic               out_strobe,
  output fexp_pkg::out_t     out_data
);

  fexp_pkg::pipe_t stg [fexp_pkg::LAT + 1];
  logic            x_nan;

  // no stall source: the pipeline always advances
  assign busy = 1'b0;

  // catch NaN at entry; it rides the override path to the output
  assign x_nan = (in_data.x_bits[30:23] == 8'hFF) && (in_data.x_bits[22:0] != 23'd0);

  always_comb begin
    stg[0].valid    = start & ~busy;
    stg[0].last     = in_data.last_in;
    stg[0].ovr      = x_nan;
    stg[0].ovr_bits = in_data.x_bits | fexp_pkg::F_QNAN;
    stg[0].acc      = in_data.x_bits;
    stg[0].t        = 32'd0;
    stg[0].pow2     = 32'd0;
  end

  // z = x * log2(e)/4
  fexp_fop #(
    .OP  (fexp_pkg::OP_TAB[0]),
    .SRC (fexp_pkg::SRC_TAB[0]),
    .KVAL(fexp_pkg::CONST_TAB[0]),
    .WRT (fexp_pkg::WRT_TAB[0])
  ) u_z (
    .clk   (clk),
    .rst_n (rst_n),
    .i_pipe(stg[0]),
    .o_pipe(stg[1])
  );

  // floor, -n, 2^n and the range checks on z
  fexp_floor u_floor (
    .clk   (clk),
    .rst_n (rst_n),
    .i_pipe(stg[1]),
    .o_pipe(stg[2])
  );

  // r, h, t, Horner series, then 2^n * s^2 squared twice
  for (genvar k = 1; k < fexp_pkg::NOPS; k++) begin : g_op
    fexp_fop #(
      .OP  (fexp_pkg::OP_TAB[k]),
      .SRC (fexp_pkg::SRC_TAB[k]),
      .KVAL(fexp_pkg::CONST_TAB[k]),
      .WRT (fexp_pkg::WRT_TAB[k])
    ) u_op (
      .clk   (clk),
      .rst_n (rst_n),
      .i_pipe(stg[k + 1]),
      .o_pipe(stg[k + 2])
    );
  end

  // apply overrides, flush subnormal results to +0
  always_comb begin
    out_strobe        = stg[fexp_pkg::LAT].valid;
    out_data.last_out = stg[fexp_pkg::LAT].last;
    if (stg[fexp_pkg::LAT].ovr) out_data.y_bits = stg[fexp_pkg::LAT].ovr_bits;
    else if (stg[fexp_pkg::LAT].acc[30:23] == 8'd0) out_data.y_bits = 32'd0;
    else out_data.y_bits = stg[fexp_pkg::LAT].acc;
  end

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, fexp_pkg::LAT))
    else $error("result strobe without a matching transfer");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.last_out == $past(in_data.last_in, fexp_pkg::LAT))
    else $error("last flag out of step with its element");

  a_nan: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(x_nan, fexp_pkg::LAT) |->
      out_data.y_bits == ($past(in_data.x_bits, fexp_pkg::LAT) | fexp_pkg::F_QNAN))
    else $error("NaN input not passed through as quiet NaN");

  a_no_subn: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.y_bits[30:23] != 8'd0 || out_data.y_bits[22:0] == 23'd0)
    else $error("subnormal result not flushed");

endmodule
`default_nettype wire

[tb/float32_exp_approx_tb.sv]
`timescale 1ns / 100ps
module float32_exp_approx_tb;

  // binary32 constants used by the exponent approximation
  localparam logic [31:0] K_LOG2E_QTR = 32'h3EB8AA3B;
  localparam logic [31:0] K_LN2       = 32'h3F317218;
  localparam logic [31:0] K_HALF      = 32'h3F000000;
  localparam logic [31:0] K_FIFTH     = 32'h3E4CCCCD;
  localparam logic [31:0] K_QUARTER   = 32'h3E800000;
  localparam logic [31:0] K_THIRD     = 32'h3EAAAAAB;
  localparam logic [31:0] K_ONE       = 32'h3F800000;
  localparam logic [31:0] K_PINF      = 32'h7F800000;
  localparam logic [31:0] K_SIXTYFOUR = 32'h42800000;
  localparam int PIPE_DEPTH = 22;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  fexp_pkg::in_t  in_data = '0;
  logic busy;
  logic out_strobe;
  fexp_pkg::out_t out_data;

  fexp_pkg::out_t exp_results_q[$];
  int   mismatch_cnt = 0;
  int   checked_cnt = 0;
  int   sent_cnt = 0;
  int   special_cnt = 0;
  bit   allow_gaps = 1'b1;

  float32_exp_approx i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Round mag * 2^e2 to binary32 with round-to-nearest-even, subnormals kept.
  function automatic logic [31:0] fp_round(input logic sgn, input int e2,
                                           input logic [63:0] mag);
    int k;
    int sh;
    int q;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    if (mag == 64'd0) return {sgn, 31'd0};
    k = 63;
    while (!mag[k]) k--;
    if (k + e2 >= -126) sh = k - 23;
    else sh = -149 - e2;
    if (sh > 63) return {sgn, 31'd0};
    q = e2 + sh;
    if (sh <= 0) begin
      kept = mag << (-sh);
    end else begin
      kept = mag >> sh;
      rem  = mag & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && kept[0])) kept++;
    end
    if (kept[24]) begin
      kept = kept >> 1;
      q++;
    end
    if (!kept[23]) return {sgn, 8'd0, kept[22:0]};
    if (q + 150 >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, 8'(q + 150), kept[22:0]};
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] f);
    return {f[30:23] != 8'd0, f[22:0]};
  endfunction

  function automatic int exp_of(input logic [31:0] f);
    return ((f[30:23] == 8'd0) ? 1 : int'(f[30:23])) - 150;
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) return {sgn, 8'hFF, 23'd0};
    return fp_round(sgn, exp_of(a) + exp_of(b), 64'(sig_of(a)) * 64'(sig_of(b)));
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] big;
    logic [31:0] lit;
    int d;
    logic [63:0] av;
    logic [63:0] bw;
    logic [63:0] bv;
    logic [63:0] sum;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 31'd0) return b;
    if (b[30:0] == 31'd0) return a;
    if (a[30:0] >= b[30:0]) begin
      big = a;
      lit = b;
    end else begin
      big = b;
      lit = a;
    end
    // align the smaller operand with 34 guard bits, fold dropped bits into sticky
    d  = exp_of(big) - exp_of(lit);
    av = 64'(sig_of(big)) << 34;
    bw = 64'(sig_of(lit)) << 34;
    if (d >= 58) begin
      bv = 64'd1;
    end else begin
      bv = (bw >> d) | 64'((bw & ((64'd1 << d) - 64'd1)) != 64'd0);
    end
    sum = (big[31] ^ lit[31]) ? av - bv : av + bv;
    if (sum == 64'd0) return 32'd0;
    return fp_round(big[31], exp_of(big) - 34, sum);
  endfunction

  // Expected e^x for one binary32 bit pattern.
  function automatic logic [31:0] predict_exp(input logic [31:0] xb);
    logic [31:0] z;
    logic [31:0] nf;
    logic [31:0] t;
    logic [31:0] s;
    logic [31:0] p;
    logic [23:0] m;
    logic [23:0] ipart;
    logic frac_nz;
    int e;
    int n;
    if (xb[30:23] == 8'hFF && xb[22:0] != 23'd0) return xb | 32'h0040_0000;
    z = fp_mul(xb, K_LOG2E_QTR);
    if (!z[31] && z[30:0] >= K_SIXTYFOUR[30:0]) return K_PINF;
    if (z[31] && z[30:0] > K_SIXTYFOUR[30:0]) return 32'd0;
    // floor of z, |z| <= 64
    if (z[30:23] < 8'd127) begin
      n = (z[31] && z[30:0] != 31'd0) ? -1 : 0;
    end else begin
      e = int'(z[30:23]) - 127;
      m = sig_of(z);
      ipart = m >> (23 - e);
      frac_nz = (m & ((24'd1 << (23 - e)) - 24'd1)) != 24'd0;
      n = z[31] ? -(int'(ipart) + int'(frac_nz)) : int'(ipart);
    end
    nf = (n < 0) ? fp_round(1'b0, 0, 64'(-n)) : fp_round(1'b1, 0, 64'(n));
    t = fp_add(z, nf);
    t = fp_mul(t, K_HALF);
    t = fp_mul(t, K_LN2);
    s = fp_add(fp_mul(t, K_FIFTH), K_ONE);
    s = fp_add(fp_mul(fp_mul(s, t), K_QUARTER), K_ONE);
    s = fp_add(fp_mul(fp_mul(s, t), K_THIRD), K_ONE);
    s = fp_add(fp_mul(fp_mul(s, t), K_HALF), K_ONE);
    s = fp_add(fp_mul(s, t), K_ONE);
    p = fp_mul({1'b0, 8'(n + 127), 23'd0}, fp_mul(s, s));
    p = fp_mul(p, p);
    p = fp_mul(p, p);
    // flush a subnormal result
    if (p[30:23] == 8'd0) p = 32'd0;
    return p;
  endfunction

  // Drive one element and hold it until the transfer happens; optionally idle first.
  task automatic send_elem(input logic [31:0] xb, input logic last);
    fexp_pkg::out_t want;
    if (allow_gaps && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{x_bits: xb, last_in: last};
    do @(posedge clk); while (busy);
    want.y_bits   = predict_exp(xb);
    want.last_out = last;
    exp_results_q.push_back(want);
    sent_cnt++;
    if (want.y_bits == K_PINF || want.y_bits == 32'd0 || xb[30:23] == 8'hFF) special_cnt++;
  endtask

  // Random binary32 in the interesting range: exponent field around 2^-27 .. 2^8.
  function automatic logic [31:0] rand_working_x();
    return {1'(($urandom)), 8'($urandom_range(100, 134)), 23'($urandom)};
  endfunction

  // Check each result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (exp_results_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result y=%h last=%b",
                                          out_data.y_bits, out_data.last_out);
      end else begin
        if (out_data !== exp_results_q[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected y=%h last=%b, got y=%h last=%b",
                     exp_results_q[0].y_bits, exp_results_q[0].last_out,
                     out_data.y_bits, out_data.last_out);
        end
        checked_cnt++;
        void'(exp_results_q.pop_front());
      end
    end
  end

  task automatic test_directed();
    logic [31:0] pts[$];
    pts = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
            32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
            32'hFFAB_CDEF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
            32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000,
            32'h4331_7218, 32'h4331_7217, 32'hC331_7218, 32'hC331_7219,
            32'h42B0_0000, 32'hC2B0_0000, 32'h42C8_0000, 32'hC2C8_0000,
            32'h3400_0000, 32'hB400_0000};
    foreach (pts[i]) send_elem(pts[i], 1'(i % 2));
  endtask

  task automatic test_random_bits();
    repeat (200) send_elem($urandom, 1'($urandom));
  endtask

  task automatic test_working_range();
    repeat (400) send_elem(rand_working_x(), 1'($urandom));
  endtask

  // Back-to-back transfers with no idle cycles.
  task automatic test_streaming();
    allow_gaps = 1'b0;
    repeat (125) send_elem(($urandom_range(0, 3) == 0) ? $urandom : rand_working_x(),
                           1'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_bits();
    test_working_range();
    test_streaming();
    start <= 1'b0;
    while (exp_results_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    $display("covered %0d elements, %0d results checked, %0d hit NaN/inf/zero paths",
             sent_cnt, checked_cnt, special_cnt);
    if (mismatch_cnt == 0 && exp_results_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
